// File: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg: shared types, codes and state tables for the bisync sequencer
// Holds the per-role transition tables, the result codes and the item types
// that both the core and its port checker use.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int SEQ_BITS = 4;          // sequence counter width, 1..8
  localparam logic [7:0] CT_ADDR = 8'h01;  // fixed peer tag in contention role

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [2:0]          rstate_t;

  typedef enum logic [1:0] {
    ROLE_PRI  = 2'd0,
    ROLE_SEC  = 2'd1,
    ROLE_CT   = 2'd2,
    ROLE_NONE = 2'd3
  } role_t;

  typedef enum logic [3:0] {
    EV_POLL_BID    = 4'd0,
    EV_LOCAL_BID   = 4'd1,
    EV_REMOTE_BID  = 4'd2,
    EV_LOCAL_EOT   = 4'd3,
    EV_REMOTE_EOT  = 4'd4,
    EV_LOCAL_FRM   = 4'd5,
    EV_REMOTE_FRM  = 4'd6,
    EV_LOCAL_HUP   = 4'd7,
    EV_REMOTE_HUP  = 4'd8,
    EV_LINK_DOWN   = 4'd9,
    EV_LINK_UP     = 4'd10,
    EV_STATE_RESET = 4'd11
  } ev_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_SEND     = 3'd1,
    ACT_FWD      = 3'd2,
    ACT_FWD_EOT  = 3'd3,
    ACT_DISC_TX  = 3'd4,
    ACT_DISC_RX  = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    TAG_NONE    = 2'd0,
    TAG_ENQ     = 2'd1,
    TAG_EOT     = 2'd2,
    TAG_DLE_EOT = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    FLT_OK       = 2'd0,
    FLT_BAD_SEQ  = 2'd1,
    FLT_BAD_ADDR = 2'd2,
    FLT_NO_MAP   = 2'd3
  } fault_t;

  // table operations, one set per role
  typedef enum logic [3:0] {
    PRI_NOP        = 4'd0,
    PRI_BID        = 4'd1,
    PRI_EOT_PEER   = 4'd2,
    PRI_REOT_CHK   = 4'd3,
    PRI_FRM_PEER   = 4'd4,
    PRI_RFRM_CHK   = 4'd5,
    PRI_DISC_TX    = 4'd7,
    PRI_DISC_RX    = 4'd8
  } pri_op_t;

  typedef enum logic [3:0] {
    SEC_NOP        = 4'd0,
    SEC_ADDR_EOT   = 4'd1,
    SEC_FWD        = 4'd2,
    SEC_EOT_PEER   = 4'd3,
    SEC_FRM_PEER   = 4'd4,
    SEC_ADDR_FWD   = 4'd5,
    SEC_DISC_TX    = 4'd7,
    SEC_DISC_RX    = 4'd8
  } sec_op_t;

  typedef enum logic [3:0] {
    CT_NOP         = 4'd0,
    CT_BID         = 4'd1,
    CT_RFRM        = 4'd2,
    CT_EOT_PEER    = 4'd3,
    CT_REOT        = 4'd4,
    CT_FRM_PEER    = 4'd5,
    CT_RFRM_CHK    = 4'd6,
    CT_NEXT_PEER   = 4'd7,
    CT_HANGUP      = 4'd8,
    CT_DISC_RX     = 4'd11,
    CT_DISC_TX     = 4'd12
  } ct_op_t;

  // [event][role state]
  localparam rstate_t PRI_NEXT [12][2] = '{
    '{3'd1, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd1}, '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}};

  localparam pri_op_t PRI_OP [12][2] = '{
    '{PRI_BID,     PRI_BID},      '{PRI_DISC_RX, PRI_FRM_PEER},
    '{PRI_DISC_TX, PRI_RFRM_CHK}, '{PRI_DISC_RX, PRI_EOT_PEER},
    '{PRI_DISC_TX, PRI_REOT_CHK}, '{PRI_DISC_RX, PRI_FRM_PEER},
    '{PRI_DISC_TX, PRI_RFRM_CHK}, '{PRI_DISC_RX, PRI_EOT_PEER},
    '{PRI_DISC_TX, PRI_REOT_CHK}, '{PRI_NOP,     PRI_NOP},
    '{PRI_NOP,     PRI_NOP},      '{PRI_NOP,     PRI_NOP}};

  localparam rstate_t SEC_NEXT [12][2] = '{
    '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd1, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd0}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}};

  localparam sec_op_t SEC_OP [12][2] = '{
    '{SEC_DISC_RX,  SEC_FRM_PEER}, '{SEC_DISC_RX, SEC_FRM_PEER},
    '{SEC_ADDR_EOT, SEC_ADDR_FWD}, '{SEC_DISC_RX, SEC_EOT_PEER},
    '{SEC_DISC_TX,  SEC_FWD},      '{SEC_DISC_RX, SEC_FRM_PEER},
    '{SEC_DISC_TX,  SEC_ADDR_FWD}, '{SEC_DISC_RX, SEC_EOT_PEER},
    '{SEC_FWD,      SEC_FWD},      '{SEC_NOP,     SEC_NOP},
    '{SEC_NOP,      SEC_NOP},      '{SEC_NOP,     SEC_NOP}};

  localparam rstate_t CT_NEXT [12][5] = '{
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1}, '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1}, '{3'd0, 3'd4, 3'd4, 3'd4, 3'd0},
    '{3'd0, 3'd4, 3'd4, 3'd4, 3'd0}, '{3'd0, 3'd3, 3'd2, 3'd3, 3'd0},
    '{3'd0, 3'd2, 3'd2, 3'd3, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}};

  localparam ct_op_t CT_OP [12][5] = '{
    '{CT_DISC_RX, CT_DISC_RX, CT_DISC_RX, CT_DISC_RX, CT_DISC_RX},
    '{CT_BID, CT_BID, CT_NEXT_PEER, CT_FRM_PEER, CT_BID},
    '{CT_RFRM, CT_RFRM, CT_RFRM_CHK, CT_RFRM, CT_RFRM},
    '{CT_DISC_RX, CT_EOT_PEER, CT_EOT_PEER, CT_EOT_PEER, CT_EOT_PEER},
    '{CT_DISC_TX, CT_REOT, CT_REOT, CT_REOT, CT_REOT},
    '{CT_DISC_RX, CT_FRM_PEER, CT_NEXT_PEER, CT_FRM_PEER, CT_DISC_RX},
    '{CT_DISC_TX, CT_RFRM_CHK, CT_RFRM_CHK, CT_RFRM, CT_DISC_TX},
    '{CT_HANGUP, CT_HANGUP, CT_HANGUP, CT_HANGUP, CT_HANGUP},
    '{CT_REOT, CT_REOT, CT_REOT, CT_REOT, CT_REOT},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP}};

  typedef struct packed {
    act_t        action;
    logic [7:0]  peer_addr;
    logic [3:0]  tag_seq;
    tag_t        tag_kind;
    fault_t      fault;
  } res_t;

  // sequence value as carried in the 4-bit tag field
  function automatic logic [3:0] seq_to_tag(seq_t s);
    logic [7:0] w;
    w = 8'(s);
    return w[3:0];
  endfunction

  // 4-bit frame sequence taken modulo 2^SEQ_BITS
  function automatic seq_t tag_to_seq(logic [3:0] f);
    logic [7:0] w;
    w = 8'(f);
    return w[SEQ_BITS-1:0];
  endfunction

endpackage

// File: src/bisync_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// bisync_frame_sequencer_core: frame sequencer for a tunneled bisync line
// Primary / secondary / contention role machine with address and sequence
// checks, one result item per frame event item.
// ----------------------------------------------------------------------------
// The block takes one frame event item per cycle and returns exactly one
// result item for it, in order. An item passes through two registers: the
// input register, where the per-role table lookup and the address/sequence
// compare are done, and the result register that feeds the out_ channel.
// out_tvalid rises when an item moves from the input register into the
// result register, which waits while a held result is not taken; sustained
// rate is one item per cycle while out_tready stays high, set by the update
// of role state, sequence count and secondary address, which the next item
// reads directly. The line role resets to unconfigured (every frame
// discarded); the user writes it through cfg_we/cfg_wdata only while no
// items are in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module bisync_frame_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,     // line role
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [4:0]  in_tuser,      // [3:0] event_req, [4] is_transmit
  input  logic [23:0] in_tdata,      // [7:0] frame_addr, [15:8] mapped_poll_addr,
                                     // [19:16] frame_seq, [23:20] zero
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,     // [2:0] action
  output logic [15:0] out_tdata      // [7:0] peer_addr, [11:8] tag_seq,
                                     // [13:12] tag_kind, [15:14] fault
);

  // configuration register
  bfs_pkg::role_t   line_role_r;

  // sequencer state
  bfs_pkg::rstate_t role_state_r, role_state_nxt;
  bfs_pkg::seq_t    seq_count_r,  seq_count_nxt;
  logic [7:0]       sec_address_r, sec_address_nxt;

  // input register
  logic             in_valid_r;
  bfs_pkg::ev_t     ev_r;
  logic             tx_r;
  logic [7:0]       raw_r;
  logic [7:0]       mapped_r;
  bfs_pkg::seq_t    fseq_r;

  // result register
  logic             out_valid_r;
  bfs_pkg::res_t    res_r, res_nxt;

  logic             adv;       // input register moves into result register

  // ---- handshake --------------------------------------------------------
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_role_r <= bfs_pkg::ROLE_NONE;
    end else if (cfg_we) begin
      line_role_r <= bfs_pkg::role_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r     <= bfs_pkg::ev_t'(in_tuser[3:0]);
      tx_r     <= in_tuser[4];
      raw_r    <= in_tdata[7:0];
      mapped_r <= in_tdata[15:8];
      fseq_r   <= bfs_pkg::tag_to_seq(in_tdata[19:16]);
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // state advances only when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_state_r  <= '0;
      seq_count_r   <= '0;
      sec_address_r <= '0;
    end else if (adv) begin
      role_state_r  <= role_state_nxt;
      seq_count_r   <= seq_count_nxt;
      sec_address_r <= sec_address_nxt;
    end
  end

  // ---- role machine -----------------------------------------------------
  always_comb begin
    logic              st_p;      // state index, primary/secondary
    bfs_pkg::rstate_t  st_c;      // state index, contention
    bfs_pkg::seq_t     seq_inc;
    bfs_pkg::pri_op_t  pop;
    bfs_pkg::sec_op_t  sop;
    bfs_pkg::ct_op_t   cop;

    role_state_nxt  = role_state_r;
    seq_count_nxt   = seq_count_r;
    sec_address_nxt = sec_address_r;
    res_nxt         = '{action: bfs_pkg::ACT_NONE, peer_addr: 8'h00, tag_seq: 4'h0,
                        tag_kind: bfs_pkg::TAG_NONE, fault: bfs_pkg::FLT_OK};

    // out-of-range role state reads as idle
    st_p    = (role_state_r > 3'd1) ? 1'b0 : role_state_r[0];
    st_c    = (role_state_r > 3'd4) ? 3'd0 : role_state_r;
    seq_inc = seq_count_r + bfs_pkg::seq_t'(1);
    pop     = bfs_pkg::PRI_NOP;
    sop     = bfs_pkg::SEC_NOP;
    cop     = bfs_pkg::CT_NOP;

    if (line_role_r == bfs_pkg::ROLE_NONE) begin
      res_nxt.action = tx_r ? bfs_pkg::ACT_DISC_TX : bfs_pkg::ACT_DISC_RX;
    end else if (ev_r <= bfs_pkg::EV_STATE_RESET) begin
      unique case (line_role_r)
        bfs_pkg::ROLE_PRI: begin
          if (tx_r && (sec_address_r != mapped_r)) begin
            // address check ahead of the table
            res_nxt.action = bfs_pkg::ACT_DISC_TX;
            res_nxt.fault  = bfs_pkg::FLT_BAD_ADDR;
          end else begin
            role_state_nxt = bfs_pkg::PRI_NEXT[ev_r][st_p];
            pop            = bfs_pkg::PRI_OP[ev_r][st_p];
            unique case (pop)
              bfs_pkg::PRI_BID: begin
                if (mapped_r == 8'h00) begin
                  res_nxt.action = bfs_pkg::ACT_DISC_RX;
                  res_nxt.fault  = bfs_pkg::FLT_NO_MAP;
                end else begin
                  sec_address_nxt   = mapped_r;
                  seq_count_nxt     = seq_inc;
                  res_nxt.action    = bfs_pkg::ACT_SEND;
                  res_nxt.peer_addr = mapped_r;
                  res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_inc);
                  res_nxt.tag_kind  = bfs_pkg::TAG_ENQ;
                end
              end
              bfs_pkg::PRI_EOT_PEER: begin
                res_nxt.action    = bfs_pkg::ACT_SEND;
                res_nxt.peer_addr = sec_address_r;
                res_nxt.tag_kind  = bfs_pkg::TAG_EOT;
              end
              bfs_pkg::PRI_REOT_CHK: begin
                // zero is accepted as well as the running count
                if ((fseq_r != '0) && (fseq_r != seq_count_r)) begin
                  res_nxt.action = bfs_pkg::ACT_DISC_TX;
                  res_nxt.fault  = bfs_pkg::FLT_BAD_SEQ;
                end else begin
                  res_nxt.action = bfs_pkg::ACT_FWD;
                  role_state_nxt = '0;
                end
              end
              bfs_pkg::PRI_FRM_PEER: begin
                seq_count_nxt     = seq_inc;
                res_nxt.action    = bfs_pkg::ACT_SEND;
                res_nxt.peer_addr = sec_address_r;
                res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_inc);
              end
              bfs_pkg::PRI_RFRM_CHK: begin
                if (fseq_r != seq_count_r) begin
                  res_nxt.action = bfs_pkg::ACT_DISC_TX;
                  res_nxt.fault  = bfs_pkg::FLT_BAD_SEQ;
                end else begin
                  res_nxt.action = bfs_pkg::ACT_FWD;
                end
              end
              bfs_pkg::PRI_DISC_TX: res_nxt.action = bfs_pkg::ACT_DISC_TX;
              bfs_pkg::PRI_DISC_RX: res_nxt.action = bfs_pkg::ACT_DISC_RX;
              default: ;
            endcase
          end
        end

        bfs_pkg::ROLE_SEC: begin
          role_state_nxt = bfs_pkg::SEC_NEXT[ev_r][st_p];
          sop            = bfs_pkg::SEC_OP[ev_r][st_p];
          unique case (sop)
            bfs_pkg::SEC_ADDR_EOT: begin
              sec_address_nxt = raw_r;
              seq_count_nxt   = fseq_r;
              res_nxt.action  = bfs_pkg::ACT_FWD_EOT;
            end
            bfs_pkg::SEC_FWD: res_nxt.action = bfs_pkg::ACT_FWD;
            bfs_pkg::SEC_EOT_PEER: begin
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = sec_address_r;
              res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_count_r);
              res_nxt.tag_kind  = bfs_pkg::TAG_EOT;
            end
            bfs_pkg::SEC_FRM_PEER: begin
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = sec_address_r;
              res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_count_r);
            end
            bfs_pkg::SEC_ADDR_FWD: begin
              sec_address_nxt = raw_r;
              seq_count_nxt   = fseq_r;
              res_nxt.action  = bfs_pkg::ACT_FWD;
            end
            bfs_pkg::SEC_DISC_TX: res_nxt.action = bfs_pkg::ACT_DISC_TX;
            bfs_pkg::SEC_DISC_RX: res_nxt.action = bfs_pkg::ACT_DISC_RX;
            default: ;
          endcase
        end

        bfs_pkg::ROLE_CT: begin
          role_state_nxt = bfs_pkg::CT_NEXT[ev_r][st_c];
          cop            = bfs_pkg::CT_OP[ev_r][st_c];
          unique case (cop)
            bfs_pkg::CT_BID: begin
              seq_count_nxt     = bfs_pkg::seq_t'(1);
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = bfs_pkg::CT_ADDR;
              res_nxt.tag_seq   = bfs_pkg::seq_to_tag(bfs_pkg::seq_t'(1));
              res_nxt.tag_kind  = bfs_pkg::TAG_ENQ;
            end
            bfs_pkg::CT_RFRM: begin
              seq_count_nxt  = fseq_r;
              res_nxt.action = bfs_pkg::ACT_FWD;
            end
            bfs_pkg::CT_EOT_PEER: begin
              seq_count_nxt     = '0;
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = bfs_pkg::CT_ADDR;
              res_nxt.tag_kind  = bfs_pkg::TAG_EOT;
            end
            bfs_pkg::CT_REOT: begin
              seq_count_nxt  = '0;
              res_nxt.action = bfs_pkg::ACT_FWD;
            end
            bfs_pkg::CT_FRM_PEER: begin
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = bfs_pkg::CT_ADDR;
              res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_count_r);
            end
            bfs_pkg::CT_RFRM_CHK: begin
              if (fseq_r != seq_count_r) begin
                res_nxt.action = bfs_pkg::ACT_DISC_TX;
                res_nxt.fault  = bfs_pkg::FLT_BAD_SEQ;
              end else begin
                res_nxt.action = bfs_pkg::ACT_FWD;
              end
            end
            bfs_pkg::CT_NEXT_PEER: begin
              seq_count_nxt     = seq_inc;
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = bfs_pkg::CT_ADDR;
              res_nxt.tag_seq   = bfs_pkg::seq_to_tag(seq_inc);
            end
            bfs_pkg::CT_HANGUP: begin
              seq_count_nxt     = '0;
              res_nxt.action    = bfs_pkg::ACT_SEND;
              res_nxt.peer_addr = bfs_pkg::CT_ADDR;
              res_nxt.tag_kind  = bfs_pkg::TAG_DLE_EOT;
            end
            bfs_pkg::CT_DISC_RX: res_nxt.action = bfs_pkg::ACT_DISC_RX;
            bfs_pkg::CT_DISC_TX: res_nxt.action = bfs_pkg::ACT_DISC_TX;
            default: ;
          endcase
        end

        default: ;
      endcase
    end
    // event codes above state reset: no-op, state holds
  end

  // ---- outputs ----------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {res_r.fault, res_r.tag_kind, res_r.tag_seq, res_r.peer_addr};

endmodule

// File: src/bfs_checker.sv
// ----------------------------------------------------------------------------
// bfs_checker: port-level checks for the bisync frame sequencer
// Watches the top-level ports only; bound into the core below.
// ----------------------------------------------------------------------------
module bfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [15:0] out_tdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= bfs_pkg::ACT_DISC_RX)
    else $error("action code out of range");

  // peer address and tag fields only travel with a send to peer
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != bfs_pkg::ACT_SEND) |-> out_tdata[13:0] == 14'h0)
    else $error("tag fields set without send");

  // any fault means the frame was dropped
  a_fault_disc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:14] != bfs_pkg::FLT_OK) |->
      (out_tuser == bfs_pkg::ACT_DISC_TX) || (out_tuser == bfs_pkg::ACT_DISC_RX))
    else $error("fault without discard");

endmodule

bind bisync_frame_sequencer_core bfs_checker u_bfs_checker (.*);

// File: bench/bisync_frame_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bisync_frame_sequencer_core_tb: self-checking bench for the frame sequencer
// A directed table of frame events, then random event streams in every role,
// scored against an in-bench model of the role machine or, for typed rows, a
// hand-written result, with random back-pressure on both item channels.
// ----------------------------------------------------------------------------
module bisync_frame_sequencer_core_tb;
  import bfs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [3:0] SEQ_MASK = 4'((1 << SEQ_BITS) - 1);
  // event codes with no meaning; a configured role ignores them
  localparam logic [3:0] EV_FIRST_FREE = 4'd12;
  localparam logic [3:0] EV_LAST_FREE  = 4'd15;

  typedef struct packed {
    logic       is_tx;
    logic [3:0] ev;
    logic [7:0] faddr;
    logic [7:0] maddr;
    logic [3:0] fseq;
  } frame_event_t;

  typedef struct {
    role_t        role;
    frame_event_t fe;
    bit           typed;   // expectation written out by hand
    res_t         want;
  } probe_row_t;

  // role machine tables, [event][role state]
  localparam logic [2:0] PRIM_TO [12][2] = '{
    '{3'd1, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd1}, '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}};
  localparam pri_op_t PRIM_DO [12][2] = '{
    '{PRI_BID, PRI_BID},          '{PRI_DISC_RX, PRI_FRM_PEER},
    '{PRI_DISC_TX, PRI_RFRM_CHK}, '{PRI_DISC_RX, PRI_EOT_PEER},
    '{PRI_DISC_TX, PRI_REOT_CHK}, '{PRI_DISC_RX, PRI_FRM_PEER},
    '{PRI_DISC_TX, PRI_RFRM_CHK}, '{PRI_DISC_RX, PRI_EOT_PEER},
    '{PRI_DISC_TX, PRI_REOT_CHK}, '{PRI_NOP, PRI_NOP},
    '{PRI_NOP, PRI_NOP},          '{PRI_NOP, PRI_NOP}};
  localparam logic [2:0] SECD_TO [12][2] = '{
    '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd1, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd0}, '{3'd0, 3'd1}, '{3'd0, 3'd1}, '{3'd0, 3'd0},
    '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}, '{3'd0, 3'd0}};
  localparam sec_op_t SECD_DO [12][2] = '{
    '{SEC_DISC_RX, SEC_FRM_PEER},  '{SEC_DISC_RX, SEC_FRM_PEER},
    '{SEC_ADDR_EOT, SEC_ADDR_FWD}, '{SEC_DISC_RX, SEC_EOT_PEER},
    '{SEC_DISC_TX, SEC_FWD},       '{SEC_DISC_RX, SEC_FRM_PEER},
    '{SEC_DISC_TX, SEC_ADDR_FWD},  '{SEC_DISC_RX, SEC_EOT_PEER},
    '{SEC_FWD, SEC_FWD},           '{SEC_NOP, SEC_NOP},
    '{SEC_NOP, SEC_NOP},           '{SEC_NOP, SEC_NOP}};
  localparam logic [2:0] CONT_TO [12][5] = '{
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1}, '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd1}, '{3'd0, 3'd4, 3'd4, 3'd4, 3'd0},
    '{3'd0, 3'd4, 3'd4, 3'd4, 3'd0}, '{3'd0, 3'd3, 3'd2, 3'd3, 3'd0},
    '{3'd0, 3'd2, 3'd2, 3'd3, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}};
  localparam ct_op_t CONT_DO [12][5] = '{
    '{CT_DISC_RX, CT_DISC_RX, CT_DISC_RX, CT_DISC_RX, CT_DISC_RX},
    '{CT_BID, CT_BID, CT_NEXT_PEER, CT_FRM_PEER, CT_BID},
    '{CT_RFRM, CT_RFRM, CT_RFRM_CHK, CT_RFRM, CT_RFRM},
    '{CT_DISC_RX, CT_EOT_PEER, CT_EOT_PEER, CT_EOT_PEER, CT_EOT_PEER},
    '{CT_DISC_TX, CT_REOT, CT_REOT, CT_REOT, CT_REOT},
    '{CT_DISC_RX, CT_FRM_PEER, CT_NEXT_PEER, CT_FRM_PEER, CT_DISC_RX},
    '{CT_DISC_TX, CT_RFRM_CHK, CT_RFRM_CHK, CT_RFRM, CT_DISC_TX},
    '{CT_HANGUP, CT_HANGUP, CT_HANGUP, CT_HANGUP, CT_HANGUP},
    '{CT_REOT, CT_REOT, CT_REOT, CT_REOT, CT_REOT},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP},
    '{CT_NOP, CT_NOP, CT_NOP, CT_NOP, CT_NOP}};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [4:0]  in_tuser;    // [3:0] event_req, [4] is_transmit
  logic [23:0] in_tdata;    // [7:0] frame_addr, [15:8] mapped_poll_addr, [19:16] frame_seq
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;   // [2:0] action
  logic [15:0] out_tdata;   // [7:0] peer_addr, [11:8] tag_seq, [13:12] tag_kind,
                            // [15:14] fault

  // sequencer state as the bench sees it
  role_t       role_q;
  logic [2:0]  rstate_q;
  logic [3:0]  seq_q;
  logic [7:0]  saddr_q;

  res_t        awaited_results [$];
  probe_row_t  directed_rows [$];
  res_t        seen_result;
  res_t        want_result;
  int          mismatch_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  bisync_frame_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bisync_frame_sequencer_core_tb failed");
      $finish;
    end
  end

  function automatic res_t make_result(act_t a, logic [7:0] pa, logic [3:0] ps,
                                       tag_t k, fault_t f);
    return {a, pa, ps, k, f};
  endfunction

  // One frame event through the role machine: returns its result item and
  // moves the bench copy of the state along.
  task automatic advance_sequencer(input frame_event_t fe, output res_t r);
    logic [3:0] fs;
    int         ev;
    int         st;
    fs = fe.fseq & SEQ_MASK;
    ev = int'(fe.ev);
    st = int'(rstate_q);
    r  = make_result(ACT_NONE, 8'h00, 4'h0, TAG_NONE, FLT_OK);
    if (role_q == ROLE_NONE) begin
      // unconfigured: everything dropped, state frozen
      r.action = fe.is_tx ? ACT_DISC_TX : ACT_DISC_RX;
    end else if (ev > int'(EV_STATE_RESET)) begin
      // unknown event, ignored
    end else if (role_q == ROLE_PRI) begin
      if (fe.is_tx && saddr_q != fe.maddr) begin
        // address check precedes the table and leaves the state alone
        r = make_result(ACT_DISC_TX, 8'h00, 4'h0, TAG_NONE, FLT_BAD_ADDR);
      end else begin
        if (st > 1) st = 0;
        rstate_q = PRIM_TO[ev][st];
        case (PRIM_DO[ev][st])
          PRI_BID: begin
            if (fe.maddr == 8'h00) begin
              r = make_result(ACT_DISC_RX, 8'h00, 4'h0, TAG_NONE, FLT_NO_MAP);
            end else begin
              saddr_q = fe.maddr;
              seq_q   = (seq_q + 4'd1) & SEQ_MASK;
              r = make_result(ACT_SEND, saddr_q, seq_q, TAG_ENQ, FLT_OK);
            end
          end
          PRI_EOT_PEER: r = make_result(ACT_SEND, saddr_q, 4'h0, TAG_EOT, FLT_OK);
          PRI_REOT_CHK: begin
            // zero always passes on a remote EOT or hangup
            if (fs != 4'h0 && fs != seq_q) begin
              r = make_result(ACT_DISC_TX, 8'h00, 4'h0, TAG_NONE, FLT_BAD_SEQ);
            end else begin
              r = make_result(ACT_FWD, 8'h00, 4'h0, TAG_NONE, FLT_OK);
              rstate_q = 3'd0;
            end
          end
          PRI_FRM_PEER: begin
            seq_q = (seq_q + 4'd1) & SEQ_MASK;
            r = make_result(ACT_SEND, saddr_q, seq_q, TAG_NONE, FLT_OK);
          end
          PRI_RFRM_CHK: begin
            if (fs != seq_q) r = make_result(ACT_DISC_TX, 8'h00, 4'h0, TAG_NONE, FLT_BAD_SEQ);
            else r = make_result(ACT_FWD, 8'h00, 4'h0, TAG_NONE, FLT_OK);
          end
          PRI_DISC_TX: r.action = ACT_DISC_TX;
          PRI_DISC_RX: r.action = ACT_DISC_RX;
          default: ;
        endcase
      end
    end else if (role_q == ROLE_SEC) begin
      if (st > 1) st = 0;
      rstate_q = SECD_TO[ev][st];
      case (SECD_DO[ev][st])
        SEC_ADDR_EOT: begin
          saddr_q  = fe.faddr;
          seq_q    = fs;
          r.action = ACT_FWD_EOT;
        end
        SEC_FWD:      r.action = ACT_FWD;
        SEC_EOT_PEER: r = make_result(ACT_SEND, saddr_q, seq_q, TAG_EOT, FLT_OK);
        SEC_FRM_PEER: r = make_result(ACT_SEND, saddr_q, seq_q, TAG_NONE, FLT_OK);
        SEC_ADDR_FWD: begin
          saddr_q  = fe.faddr;
          seq_q    = fs;
          r.action = ACT_FWD;
        end
        SEC_DISC_TX:  r.action = ACT_DISC_TX;
        SEC_DISC_RX:  r.action = ACT_DISC_RX;
        default: ;
      endcase
    end else begin
      if (st > 4) st = 0;
      rstate_q = CONT_TO[ev][st];
      case (CONT_DO[ev][st])
        CT_BID: begin
          seq_q = 4'd1 & SEQ_MASK;
          r = make_result(ACT_SEND, CT_ADDR, seq_q, TAG_ENQ, FLT_OK);
        end
        CT_RFRM: begin
          seq_q    = fs;
          r.action = ACT_FWD;
        end
        CT_EOT_PEER: begin
          r = make_result(ACT_SEND, CT_ADDR, 4'h0, TAG_EOT, FLT_OK);
          seq_q = 4'h0;
        end
        CT_REOT: begin
          r.action = ACT_FWD;
          seq_q    = 4'h0;
        end
        CT_FRM_PEER: r = make_result(ACT_SEND, CT_ADDR, seq_q, TAG_NONE, FLT_OK);
        CT_RFRM_CHK: begin
          if (fs != seq_q) r = make_result(ACT_DISC_TX, 8'h00, 4'h0, TAG_NONE, FLT_BAD_SEQ);
          else r.action = ACT_FWD;
        end
        CT_NEXT_PEER: begin
          seq_q = (seq_q + 4'd1) & SEQ_MASK;
          r = make_result(ACT_SEND, CT_ADDR, seq_q, TAG_NONE, FLT_OK);
        end
        CT_HANGUP: begin
          seq_q = 4'h0;
          r = make_result(ACT_SEND, CT_ADDR, 4'h0, TAG_DLE_EOT, FLT_OK);
        end
        CT_DISC_RX: r.action = ACT_DISC_RX;
        CT_DISC_TX: r.action = ACT_DISC_TX;
        default: ;
      endcase
    end
  endtask

  task automatic add_probe(input role_t role, input logic [3:0] ev, input logic tx,
                           input logic [7:0] fa, input logic [7:0] ma,
                           input logic [3:0] fs, input bit typed, input act_t a,
                           input logic [7:0] pa, input logic [3:0] ps, input tag_t k,
                           input fault_t f);
    probe_row_t p;
    p.role  = role;
    p.fe    = {tx, ev, fa, ma, fs};
    p.typed = typed;
    p.want  = make_result(a, pa, ps, k, f);
    directed_rows.push_back(p);
  endtask

  // Mostly well-formed traffic for the current role: remote events flagged as
  // transmit, primary transmit frames carrying the bound address, sequence
  // numbers that usually match. The rest is unrestricted noise.
  function automatic frame_event_t pick_event();
    frame_event_t fe;
    int           roll;
    if ($urandom_range(0, 99) < 15) begin
      fe.is_tx = 1'($urandom);
      fe.ev    = 4'($urandom);
      fe.faddr = 8'($urandom);
      fe.maddr = 8'($urandom);
      fe.fseq  = 4'($urandom);
    end else begin
      fe.ev    = 4'($urandom_range(0, EV_STATE_RESET));
      fe.is_tx = (fe.ev == EV_REMOTE_BID || fe.ev == EV_REMOTE_EOT ||
                  fe.ev == EV_REMOTE_FRM || fe.ev == EV_REMOTE_HUP);
      fe.faddr = 8'($urandom);
      if (role_q == ROLE_PRI && fe.is_tx) fe.maddr = saddr_q;
      else if ($urandom_range(0, 9) == 0) fe.maddr = 8'h00;
      else fe.maddr = 8'($urandom_range(1, 255));
      roll = $urandom_range(0, 3);
      if (roll < 2) fe.fseq = seq_q;
      else if (roll == 2) fe.fseq = 4'h0;
      else fe.fseq = 4'($urandom);
    end
    return fe;
  endfunction

  // Offer one item, with random gaps ahead of it; valid stays up afterward
  // so back-to-back items never toggle it within a step.
  task automatic send_event(input frame_event_t fe, input bit typed, input res_t known);
    res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {fe.is_tx, fe.ev};
    in_tdata  <= {4'h0, fe.fseq, fe.maddr, fe.faddr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_sequencer(fe, predicted);
    awaited_results.push_back(typed ? known : predicted);
  endtask

  // Role change only with the pipe drained.
  task automatic set_role(input role_t r);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    role_q     = r;
  endtask

  task automatic log_mismatch(input string why, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp act=%0d addr=%02h seq=%0d kind=%0d fault=%0d, got act=%0d addr=%02h seq=%0d kind=%0d fault=%0d",
               $time, why, want.action, want.peer_addr, want.tag_seq, want.tag_kind,
               want.fault, got.action, got.peer_addr, got.tag_seq, got.tag_kind, got.fault);
  endtask

  // result side: score each accepted item, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = {out_tuser, out_tdata[7:0], out_tdata[11:8], out_tdata[13:12],
                     out_tdata[15:14]};
      if (awaited_results.size() == 0) begin
        log_mismatch("unexpected result", '0, seen_result);
      end else begin
        want_result = awaited_results.pop_front();
        if (seen_result.action !== want_result.action ||
            seen_result.peer_addr !== want_result.peer_addr ||
            seen_result.tag_seq !== want_result.tag_seq ||
            seen_result.tag_kind !== want_result.tag_kind ||
            seen_result.fault !== want_result.fault)
          log_mismatch("result mismatch", want_result, seen_result);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    role_t phase_roles [4];
    int    ph;
    int    n;
    phase_roles    = '{ROLE_PRI, ROLE_SEC, ROLE_CT, ROLE_NONE};
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 2'b00;
    in_tvalid      = 1'b0;
    in_tuser       = '0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    tx_idle_pct    = 21;
    rx_idle_pct    = 64;
    role_q         = ROLE_NONE;   // register reset value
    rstate_q       = 3'd0;
    seq_q          = 4'h0;
    saddr_q        = 8'h00;

    //        role       event           tx    faddr  maddr  fseq  typed result
    // unconfigured after reset: all dropped by direction
    add_probe(ROLE_NONE, EV_POLL_BID,    1'b1, 8'hFF, 8'hFF, 4'hF, 1, ACT_DISC_TX,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_NONE, EV_LAST_FREE,   1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_DISC_RX,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // primary: bid with no mapping still moves the state
    add_probe(ROLE_PRI,  EV_POLL_BID,    1'b0, 8'hFF, 8'h00, 4'h0, 1, ACT_DISC_RX,
              8'h00, 4'h0, TAG_NONE, FLT_NO_MAP);
    add_probe(ROLE_PRI,  EV_POLL_BID,    1'b0, 8'h12, 8'h40, 4'h0, 1, ACT_SEND,
              8'h40, 4'h1, TAG_ENQ, FLT_OK);
    add_probe(ROLE_PRI,  EV_REMOTE_FRM,  1'b1, 8'h00, 8'h40, 4'h1, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_REMOTE_FRM,  1'b1, 8'h00, 8'h40, 4'h3, 1, ACT_DISC_TX,
              8'h00, 4'h0, TAG_NONE, FLT_BAD_SEQ);
    add_probe(ROLE_PRI,  EV_REMOTE_EOT,  1'b1, 8'h00, 8'h41, 4'h0, 1, ACT_DISC_TX,
              8'h00, 4'h0, TAG_NONE, FLT_BAD_ADDR);
    add_probe(ROLE_PRI,  EV_LOCAL_FRM,   1'b0, 8'h00, 8'h40, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_LOCAL_EOT,   1'b0, 8'h00, 8'h40, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_POLL_BID,    1'b0, 8'h00, 8'h40, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // remote EOT with sequence zero is always accepted
    add_probe(ROLE_PRI,  EV_REMOTE_EOT,  1'b1, 8'h00, 8'h40, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_POLL_BID,    1'b0, 8'h00, 8'h40, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_REMOTE_HUP,  1'b1, 8'h00, 8'h40, 4'h7, 1, ACT_DISC_TX,
              8'h00, 4'h0, TAG_NONE, FLT_BAD_SEQ);
    add_probe(ROLE_PRI,  EV_REMOTE_HUP,  1'b1, 8'h00, 8'h40, 4'h4, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // unknown event wins over the address check
    add_probe(ROLE_PRI,  EV_FIRST_FREE,  1'b1, 8'h00, 8'h99, 4'h0, 1, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_PRI,  EV_LINK_DOWN,   1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // secondary: remote bid binds the address and forwards with EOT prefix
    add_probe(ROLE_SEC,  EV_REMOTE_BID,  1'b1, 8'hC1, 8'h00, 4'h5, 1, ACT_FWD_EOT,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_SEC,  EV_LOCAL_FRM,   1'b0, 8'h00, 8'h00, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_SEC,  EV_STATE_RESET, 1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // contention: fixed peer tag
    add_probe(ROLE_CT,   EV_LOCAL_BID,   1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_SEND,
              CT_ADDR, 4'h1, TAG_ENQ, FLT_OK);
    add_probe(ROLE_CT,   EV_LOCAL_EOT,   1'b0, 8'h00, 8'h00, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    // contention state left behind is out of range for secondary: idle
    add_probe(ROLE_SEC,  EV_LOCAL_FRM,   1'b0, 8'h00, 8'h00, 4'h0, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_CT,   EV_REMOTE_FRM,  1'b1, 8'h00, 8'h00, 4'h9, 0, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);
    add_probe(ROLE_CT,   EV_LOCAL_HUP,   1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_SEND,
              CT_ADDR, 4'h0, TAG_DLE_EOT, FLT_OK);
    add_probe(ROLE_CT,   EV_STATE_RESET, 1'b0, 8'h00, 8'h00, 4'h0, 1, ACT_NONE,
              8'h00, 4'h0, TAG_NONE, FLT_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].role != role_q) set_role(directed_rows[i].role);
      send_event(directed_rows[i].fe, directed_rows[i].typed, directed_rows[i].want);
    end

    // random streams: each role in turn, idling swaps sides then stops;
    // the sequencer state carries over across role changes on purpose
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 64;
        rx_idle_pct = 21;
      end else if (ph == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_role(phase_roles[ph % 4]);
      n = (role_q == ROLE_NONE) ? 10 : 45;
      repeat (n) send_event(pick_event(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bisync_frame_sequencer_core_tb passed");
    end else begin
      $display("bisync_frame_sequencer_core_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bfs_pkg.sv
src/bisync_frame_sequencer_core.sv
src/bfs_checker.sv
bench/bisync_frame_sequencer_core_tb.sv
